// File: rtl/core/mf3x3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3x3_pkg
// Types, register indexes and the median network of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3x3_pkg;

  typedef logic [7:0] pix_t;

  // 3x3 window, row-major: top row 0..2, middle 3..5, bottom 6..8
  typedef logic [8:0][7:0] win_t;

  typedef struct packed {
    logic req_type;
    pix_t pixel;
  } mf3x3_in_t;

  typedef struct packed {
    pix_t median;
    logic row_end;
    logic frame_end;
  } mf3x3_out_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH = 1'b0,
    CFG_ROW_COUNT  = 1'b1
  } cfg_idx_t;

  localparam int ROW_LENGTH_W = 11;
  localparam int ROW_COUNT_W  = 13;
  localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RST = 11'd1024;
  localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RST  = 13'd1;

  // Median of nine through a 19 compare-exchange network.
  function automatic pix_t median9(input win_t w);
    win_t p;
    pix_t tmp;
    p = w;
    if (p[1] > p[2]) begin tmp = p[1]; p[1] = p[2]; p[2] = tmp; end
    if (p[4] > p[5]) begin tmp = p[4]; p[4] = p[5]; p[5] = tmp; end
    if (p[7] > p[8]) begin tmp = p[7]; p[7] = p[8]; p[8] = tmp; end
    if (p[0] > p[1]) begin tmp = p[0]; p[0] = p[1]; p[1] = tmp; end
    if (p[3] > p[4]) begin tmp = p[3]; p[3] = p[4]; p[4] = tmp; end
    if (p[6] > p[7]) begin tmp = p[6]; p[6] = p[7]; p[7] = tmp; end
    if (p[1] > p[2]) begin tmp = p[1]; p[1] = p[2]; p[2] = tmp; end
    if (p[4] > p[5]) begin tmp = p[4]; p[4] = p[5]; p[5] = tmp; end
    if (p[7] > p[8]) begin tmp = p[7]; p[7] = p[8]; p[8] = tmp; end
    if (p[0] > p[3]) begin tmp = p[0]; p[0] = p[3]; p[3] = tmp; end
    if (p[5] > p[8]) begin tmp = p[5]; p[5] = p[8]; p[8] = tmp; end
    if (p[4] > p[7]) begin tmp = p[4]; p[4] = p[7]; p[7] = tmp; end
    if (p[3] > p[6]) begin tmp = p[3]; p[3] = p[6]; p[6] = tmp; end
    if (p[1] > p[4]) begin tmp = p[1]; p[1] = p[4]; p[4] = tmp; end
    if (p[2] > p[5]) begin tmp = p[2]; p[2] = p[5]; p[5] = tmp; end
    if (p[4] > p[7]) begin tmp = p[4]; p[4] = p[7]; p[7] = tmp; end
    if (p[4] > p[2]) begin tmp = p[4]; p[4] = p[2]; p[2] = tmp; end
    if (p[6] > p[4]) begin tmp = p[6]; p[6] = p[4]; p[4] = tmp; end
    if (p[4] > p[2]) begin tmp = p[4]; p[4] = p[2]; p[2] = tmp; end
    return p[4];
  endfunction

endpackage

// File: rtl/core/median_filter_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for 8-bit grey images with edge replication.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, when not stalled, in raster order and returns,
// one row late, the median of each pixel's 3x3 neighbourhood (borders
// replicated). After the last image row, send one row of flush items
// (req_type 1) to push out the final row. The last item of an output row
// gives two results and holds the median stage for both, but the first item
// of the next row gives none, so the input stalls only when the output
// stalls. After an input transfer the line buffers are read into stage A;
// stage A then updates the window and hands a snapshot of it to stage C,
// and stage C registers the median network into the output register, each
// step waiting while the next one is busy. The second result of a row's
// last item comes from the same stage C snapshot. The two line buffers are
// MAX_ROW_LENGTH x 8 RAMs with one write and one registered read per cycle;
// a write to the column being read in the same cycle is forwarded. The
// buffers need no clearing after reset. Items of the wrong kind (flush while
// image rows are due, pixel while the flush row is due) are taken and
// dropped. Write row_length and row_count only while the block is idle.
module median_filter_3x3
  import mf3x3_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mf3x3_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mf3x3_out_t            out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_ROW_LENGTH);
  localparam int LW0 = $clog2(MAX_ROW_LENGTH + 1);
  localparam int LW = (LW0 > ROW_LENGTH_W) ? LW0 : ROW_LENGTH_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_ROW_LENGTH);

  // configuration
  logic [ROW_LENGTH_W-1:0] row_length_r;
  logic [ROW_COUNT_W-1:0]  row_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RST;
      row_count_r  <= ROW_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROW_LENGTH: row_length_r <= cfg_data[ROW_LENGTH_W-1:0];
        CFG_ROW_COUNT:  row_count_r  <= cfg_data[ROW_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0]          len_raw, len_eff;
  logic [ROW_COUNT_W-1:0] rc_eff;

  always_comb begin
    len_raw = LW'(row_length_r);
    if (len_raw == '0)
      len_eff = LW'(1);
    else if (len_raw > MAX_LEN)
      len_eff = MAX_LEN;
    else
      len_eff = len_raw;
    rc_eff = (row_count_r == '0) ? ROW_COUNT_W'(1) : row_count_r;
  end

  // position counters, advanced only for input items of the expected kind
  logic [CW-1:0]          col_r, col_nxt;
  logic [ROW_COUNT_W-1:0] row_r, row_nxt;

  logic in_xfer, take, flush_phase, last_cur;

  // stage A: accepted item plus line-buffer read data
  logic          a_valid_r, a_valid_nxt;
  logic [CW-1:0] a_col_r;
  logic          a_emit_r, a_top_r, a_flush_r, a_last_r, a_colz_r;
  pix_t          a_px_r;
  logic          a_fwd_r;
  pix_t          a_fwd_up_r, a_fwd_mid_r;
  pix_t          up_q_r, mid_q_r;
  logic          a_fire, a_has;
  pix_t          a_t, a_m, a_b;

  // stage C: window snapshot waiting for the median unit
  logic c_valid_r, c_valid_nxt;
  win_t c_win_r;
  logic c_two_r, c_last_r, c_flush_r, c_sel_r, c_sel_nxt;
  logic c_free;

  // output register
  logic       out_valid_r, out_valid_nxt;
  mf3x3_out_t out_r;
  logic       out_load;

  win_t win_r, win_a, win_b;

  assign flush_phase = (row_r >= rc_eff);
  assign last_cur    = ((LW'(col_r) + LW'(1)) >= len_eff);
  assign in_stall    = a_valid_r && !a_fire;
  assign in_xfer     = in_valid && !in_stall;
  assign take        = in_xfer && (in_data.req_type == flush_phase);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (last_cur) begin
        col_nxt = '0;
        row_nxt = flush_phase ? '0 : row_r + ROW_COUNT_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line buffers
  pix_t upper_mem [MAX_ROW_LENGTH];
  pix_t middle_mem [MAX_ROW_LENGTH];

  always_ff @(posedge clk) begin
    if (a_fire)
      upper_mem[a_col_r] <= a_m;
    if (take)
      up_q_r <= upper_mem[col_r];
  end

  always_ff @(posedge clk) begin
    if (a_fire)
      middle_mem[a_col_r] <= a_b;
    if (take)
      mid_q_r <= middle_mem[col_r];
  end

  // stage A data path
  always_comb begin
    a_m = a_fwd_r ? a_fwd_mid_r : mid_q_r;
    a_t = a_top_r ? (a_fwd_r ? a_fwd_up_r : up_q_r) : a_m;
    a_b = a_flush_r ? a_m : a_px_r;
    a_has = a_emit_r && (!a_colz_r || a_last_r);
  end

  assign a_fire = a_valid_r && (!a_has || c_free);
  assign a_valid_nxt = take || (a_valid_r && !a_fire);

  always_ff @(posedge clk) begin
    if (!rst_n)
      a_valid_r <= 1'b0;
    else
      a_valid_r <= a_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_col_r     <= col_r;
      a_emit_r    <= (row_r >= ROW_COUNT_W'(1));
      a_top_r     <= (row_r >= ROW_COUNT_W'(2));
      a_flush_r   <= flush_phase;
      a_last_r    <= last_cur;
      a_colz_r    <= (col_r == '0);
      a_px_r      <= in_data.pixel;
      // previous item writes this column in the same cycle
      a_fwd_r     <= a_fire && (a_col_r == col_r);
      a_fwd_up_r  <= a_m;
      a_fwd_mid_r <= a_b;
    end
  end

  // window after the first step (win_a) and after a second shift (win_b)
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pix_t v;
      v = (r == 0) ? a_t : (r == 1) ? a_m : a_b;
      if (a_colz_r) begin
        win_a[r*3+0] = v;
        win_a[r*3+1] = v;
        win_a[r*3+2] = v;
      end else begin
        win_a[r*3+0] = win_r[r*3+1];
        win_a[r*3+1] = win_r[r*3+2];
        win_a[r*3+2] = v;
      end
      win_b[r*3+0] = win_a[r*3+1];
      win_b[r*3+1] = win_a[r*3+2];
      win_b[r*3+2] = win_a[r*3+2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      win_r <= '0;
    else if (a_fire && a_emit_r)
      win_r <= (!a_colz_r && a_last_r) ? win_b : win_a;
  end

  // stage C and output register
  win_t c_win_cur;
  logic c_rend, c_fend;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      c_win_cur[r*3+0] = c_sel_r ? c_win_r[r*3+1] : c_win_r[r*3+0];
      c_win_cur[r*3+1] = c_sel_r ? c_win_r[r*3+2] : c_win_r[r*3+1];
      c_win_cur[r*3+2] = c_win_r[r*3+2];
    end
    c_rend = c_sel_r || (!c_two_r && c_last_r);
    c_fend = c_sel_r ? c_flush_r : (!c_two_r && c_last_r && c_flush_r);
  end

  assign out_load = c_valid_r && (!out_valid_r || !out_stall);
  assign c_free   = !c_valid_r || (out_load && (!c_two_r || c_sel_r));

  always_comb begin
    c_valid_nxt = c_valid_r;
    c_sel_nxt   = c_sel_r;
    if (out_load) begin
      if (c_two_r && !c_sel_r) begin
        c_sel_nxt = 1'b1;
      end else begin
        c_valid_nxt = 1'b0;
      end
    end
    if (a_fire && a_has) begin
      c_valid_nxt = 1'b1;
      c_sel_nxt   = 1'b0;
    end
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r   <= 1'b0;
      c_sel_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      c_valid_r   <= c_valid_nxt;
      c_sel_r     <= c_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_has) begin
      c_win_r   <= win_a;
      c_two_r   <= !a_colz_r && a_last_r;
      c_last_r  <= a_last_r;
      c_flush_r <= a_flush_r;
    end
    if (out_load) begin
      out_r.median    <= median9(c_win_cur);
      out_r.row_end   <= c_rend;
      out_r.frame_end <= c_fend;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
